// ----- rtl/refcounted_slice_allocator_macros.svh -----
// assertion macros used by the allocator top level
`ifndef REFCOUNTED_SLICE_ALLOCATOR_MACROS_SVH
`define REFCOUNTED_SLICE_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define RSA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RSA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rsa_pkg.sv -----
`default_nettype none

package rsa_pkg;

  // table sizes
  localparam int NumChannels = 256;
  localparam int ChW         = $clog2(NumChannels);
  localparam int NumSlices   = 64;
  localparam int SliceW      = $clog2(NumSlices);
  localparam int CntW        = $clog2(NumSlices + 1);
  localparam int ViewerBits  = 16;
  localparam int TimeW       = 32;
  localparam int CfgW        = 7;

  localparam logic [ViewerBits-1:0] ViewerMax = '1;

  // command queue between front and back
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // request function codes
  localparam logic FuncJoin  = 1'b0;
  localparam logic FuncLeave = 1'b1;

  // result status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StNoSlice   = 2'd1;
  localparam logic [1:0] StIdleLeave = 2'd2;

  // classified operation
  typedef enum logic [2:0] {
    OpJoinHit,
    OpJoinNew,
    OpLeaveDec,
    OpLeaveFree,
    OpLeaveIdle
  } op_e;

  // command handed from front to back
  typedef struct packed {
    op_e               op;
    logic [ChW-1:0]    channel;
    logic [TimeW-1:0]  now;
    logic [SliceW-1:0] slot;
  } cmd_t;

  // new binding reported back to the channel table
  typedef struct packed {
    logic              valid;
    logic [ChW-1:0]    channel;
    logic [SliceW-1:0] slot;
  } bind_t;

  // one channel table entry
  typedef struct packed {
    logic [SliceW-1:0]     slot;
    logic [ViewerBits-1:0] viewers;
  } chan_entry_t;

endpackage

`default_nettype wire

// ----- rtl/refcounted_slice_allocator.sv -----
// channel    direction  transfer condition            payload
// request    in         start && !busy                func_i, channel_id_i, now_i
// result     out        done_o (one cycle, no stall)  status_o .. freed_busy_time_o
// config     in         psel && penable && pwrite     pwdata at paddr
//
// a request passes channel table read, classify and queue, slice table read,
// execute; busy is registered, set by a transfer and cleared by execute
// the result strobe shows in the cycle after execute, when busy is low again
// every request gives exactly one result; the receiver cannot stall
// reset clears channel bindings, slice flags and counters at once, no sweep
`default_nettype none

`include "refcounted_slice_allocator_macros.svh"

module refcounted_slice_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       func_i,
  input  logic [rsa_pkg::ChW-1:0]    channel_id_i,
  input  logic [rsa_pkg::TimeW-1:0]  now_i,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [rsa_pkg::SliceW-1:0] slice_index_o,
  output logic                       slice_freed_o,
  output logic [rsa_pkg::CntW-1:0]   slices_busy_o,
  output logic [rsa_pkg::SliceW-1:0] peak_slice_o,
  output logic [rsa_pkg::TimeW-1:0]  freed_busy_time_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import rsa_pkg::*;

  localparam logic            RegSlicesInUse   = 1'b0;
  localparam logic [CfgW-1:0] SlicesInUseReset = CfgW'(64);

  logic            accept;
  logic            busy_q, busy_d;
  logic [CfgW-1:0] slices_in_use_q, slices_in_use_d;
  logic            cfg_wr;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_valid;
  cmd_t            front_cmd;
  cmd_t            queue_cmd;
  bind_t           bind_fb;
  logic            exec;

  // configuration register
  assign pready          = 1'b1;
  assign cfg_wr          = psel && penable && pwrite && (paddr[2] == RegSlicesInUse);
  assign slices_in_use_d = cfg_wr ? pwdata[CfgW-1:0] : slices_in_use_q;
  assign prdata          = (paddr[2] == RegSlicesInUse) ? 32'(slices_in_use_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slices_in_use_q <= SlicesInUseReset;
    end else begin
      slices_in_use_q <= slices_in_use_d;
    end
  end

  // request in flight
  assign accept = start && !busy_q;
  assign busy_d = accept ? 1'b1 : (exec ? 1'b0 : busy_q);
  assign busy   = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // channel lookup and classification
  rsa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .func_i       (func_i),
    .channel_id_i (channel_id_i),
    .now_i        (now_i),
    .bind_i       (bind_fb),
    .full_i       (q_full),
    .push_o       (push),
    .cmd_o        (front_cmd)
  );

  // command queue
  rsa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .valid_o (q_valid)
  );

  // slice allocation and accounting
  rsa_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (q_valid),
    .cmd_i             (queue_cmd),
    .pop_o             (pop),
    .slices_in_use_i   (slices_in_use_q),
    .bind_o            (bind_fb),
    .exec_o            (exec),
    .done_o            (done_o),
    .status_o          (status_o),
    .slice_index_o     (slice_index_o),
    .slice_freed_o     (slice_freed_o),
    .slices_busy_o     (slices_busy_o),
    .peak_slice_o      (peak_slice_o),
    .freed_busy_time_o (freed_busy_time_o)
  );

  // checks
  `RSA_ASSERT_NXT(a_accept_sets_busy, accept, busy_q, "request transfer did not set busy")
  `RSA_ASSERT_IMP(a_done_ends_busy, done_o, $past(busy_q) && !busy_q, "result outside a request")
  `RSA_ASSERT_NXT(a_single_result, done_o, !done_o, "result strobe longer than one cycle")
  `RSA_ASSERT_IMP(a_freed_ok, done_o && slice_freed_o,
                  (status_o == StOk) && (slices_busy_o != CntW'(NumSlices)),
                  "freed slice with bad status or count")

endmodule

`default_nettype wire

// ----- rtl/rsa_front.sv -----
`default_nettype none

module rsa_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic                      func_i,
  input  logic [rsa_pkg::ChW-1:0]   channel_id_i,
  input  logic [rsa_pkg::TimeW-1:0] now_i,
  input  rsa_pkg::bind_t            bind_i,
  input  logic                      full_i,
  output logic                      push_o,
  output rsa_pkg::cmd_t             cmd_o
);
  import rsa_pkg::*;

  logic                  req_q, req_d;
  logic                  func_q;
  logic [ChW-1:0]        ch_q;
  logic [TimeW-1:0]      now_q;
  logic                  bound_rd_q;
  chan_entry_t           entry_q;
  chan_entry_t           chan_mem [NumChannels];
  logic [NumChannels-1:0] bound_q, bound_d;
  logic                  wr_en;
  logic [ChW-1:0]        wr_addr;
  chan_entry_t           wr_data;
  logic [ViewerBits-1:0] viewers_inc;
  logic [ViewerBits-1:0] viewers_dec;

  // pending request flag
  assign req_d = accept_i ? 1'b1 : (push_o ? 1'b0 : req_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= 1'b0;
    end else begin
      req_q <= req_d;
    end
  end

  // capture request and look up channel entry
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      func_q     <= func_i;
      ch_q       <= channel_id_i;
      now_q      <= now_i;
      bound_rd_q <= bound_q[channel_id_i];
      entry_q    <= chan_mem[channel_id_i];
    end
  end

  // viewer count update, saturating on join
  assign viewers_inc = (entry_q.viewers == ViewerMax) ? entry_q.viewers
                                                      : entry_q.viewers + 1'b1;
  assign viewers_dec = entry_q.viewers - 1'b1;

  // classify the request
  always_comb begin
    cmd_o.channel = ch_q;
    cmd_o.now     = now_q;
    cmd_o.slot    = entry_q.slot;
    if (func_q == FuncJoin) begin
      if (bound_rd_q) begin
        cmd_o.op = OpJoinHit;
      end else begin
        cmd_o.op   = OpJoinNew;
        cmd_o.slot = '0;
      end
    end else if (!bound_rd_q) begin
      cmd_o.op   = OpLeaveIdle;
      cmd_o.slot = '0;
    end else if (entry_q.viewers == ViewerBits'(1)) begin
      cmd_o.op = OpLeaveFree;
    end else begin
      cmd_o.op = OpLeaveDec;
    end
  end

  assign push_o = req_q && !full_i;

  // channel table write port: new binding from the back, else count update
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = ch_q;
    wr_data.slot    = entry_q.slot;
    wr_data.viewers = viewers_inc;
    bound_d         = bound_q;
    if (bind_i.valid) begin
      wr_en                  = 1'b1;
      wr_addr                = bind_i.channel;
      wr_data.slot           = bind_i.slot;
      wr_data.viewers        = ViewerBits'(1);
      bound_d[bind_i.channel] = 1'b1;
    end else if (push_o) begin
      case (cmd_o.op)
        OpJoinHit: begin
          wr_en = 1'b1;
        end
        OpLeaveDec: begin
          wr_en           = 1'b1;
          wr_data.viewers = viewers_dec;
        end
        OpLeaveFree: begin
          bound_d[ch_q] = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // bound flags cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q <= '0;
    end else begin
      bound_q <= bound_d;
    end
  end

  // channel table storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      chan_mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rsa_queue.sv -----
`default_nettype none

module rsa_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rsa_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output rsa_pkg::cmd_t cmd_o,
  output logic          valid_o
);
  import rsa_pkg::*;

  cmd_t                 entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/rsa_back.sv -----
`default_nettype none

module rsa_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  rsa_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  input  logic [rsa_pkg::CfgW-1:0]   slices_in_use_i,
  output rsa_pkg::bind_t             bind_o,
  output logic                       exec_o,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [rsa_pkg::SliceW-1:0] slice_index_o,
  output logic                       slice_freed_o,
  output logic [rsa_pkg::CntW-1:0]   slices_busy_o,
  output logic [rsa_pkg::SliceW-1:0] peak_slice_o,
  output logic [rsa_pkg::TimeW-1:0]  freed_busy_time_o
);
  import rsa_pkg::*;

  logic                 ex_q;
  cmd_t                 ex_cmd_q;
  logic [TimeW-1:0]     start_rd_q;
  logic [TimeW-1:0]     acc_rd_q;
  logic                 acc_valid_rd_q;
  logic [TimeW-1:0]     start_mem [NumSlices];
  logic [TimeW-1:0]     acc_mem [NumSlices];
  logic [NumSlices-1:0] busy_q, busy_d;
  logic [NumSlices-1:0] acc_valid_q, acc_valid_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [SliceW-1:0]    peak_q, peak_d;
  logic [NumSlices-1:0] avail;
  logic                 found;
  logic [SliceW-1:0]    free_idx;
  logic [TimeW-1:0]     acc_base;
  logic [TimeW-1:0]     acc_new;
  logic                 start_we;
  logic                 acc_we;
  logic [1:0]           status_d;
  logic [SliceW-1:0]    index_d;
  logic                 freed_d;
  logic [TimeW-1:0]     ftime_d;
  logic                 done_q;
  logic [1:0]           status_q;
  logic [SliceW-1:0]    index_q;
  logic                 freed_q;
  logic [TimeW-1:0]     ftime_q;

  // take a command when the execute stage is free
  assign pop_o  = valid_i && !ex_q;
  assign exec_o = ex_q;

  // slice table reads for the command taken
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ex_cmd_q       <= cmd_i;
      start_rd_q     <= start_mem[cmd_i.slot];
      acc_rd_q       <= acc_mem[cmd_i.slot];
      acc_valid_rd_q <= acc_valid_q[cmd_i.slot];
    end
  end

  // lowest free slice within the configured range
  always_comb begin
    for (int i = 0; i < NumSlices; i++) begin
      avail[i] = !busy_q[i] && (i < int'(slices_in_use_i));
    end
    found    = |avail;
    free_idx = '0;
    for (int i = NumSlices - 1; i >= 0; i--) begin
      if (avail[i]) begin
        free_idx = SliceW'(i);
      end
    end
  end

  // busy time of the slice being freed
  assign acc_base = acc_valid_rd_q ? acc_rd_q : '0;
  assign acc_new  = acc_base + ex_cmd_q.now - start_rd_q;

  // execute the command
  always_comb begin
    busy_d         = busy_q;
    acc_valid_d    = acc_valid_q;
    count_d        = count_q;
    peak_d         = peak_q;
    start_we       = 1'b0;
    acc_we         = 1'b0;
    status_d       = StOk;
    index_d        = ex_cmd_q.slot;
    freed_d        = 1'b0;
    ftime_d        = '0;
    bind_o.valid   = 1'b0;
    bind_o.channel = ex_cmd_q.channel;
    bind_o.slot    = free_idx;
    if (ex_q) begin
      case (ex_cmd_q.op)
        OpJoinNew: begin
          if (found) begin
            busy_d[free_idx] = 1'b1;
            start_we         = 1'b1;
            count_d          = count_q + 1'b1;
            if (free_idx > peak_q) begin
              peak_d = free_idx;
            end
            index_d      = free_idx;
            bind_o.valid = 1'b1;
          end else begin
            status_d = StNoSlice;
            index_d  = '0;
          end
        end
        OpLeaveFree: begin
          busy_d[ex_cmd_q.slot] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - 1'b1;
          end
          acc_we                     = 1'b1;
          acc_valid_d[ex_cmd_q.slot] = 1'b1;
          freed_d                    = 1'b1;
          ftime_d                    = acc_new;
        end
        OpLeaveIdle: begin
          status_d = StIdleLeave;
          index_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q        <= 1'b0;
      busy_q      <= '0;
      acc_valid_q <= '0;
      count_q     <= '0;
      peak_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      ex_q        <= pop_o;
      busy_q      <= busy_d;
      acc_valid_q <= acc_valid_d;
      count_q     <= count_d;
      peak_q      <= peak_d;
      done_q      <= ex_q;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (ex_q) begin
      status_q <= status_d;
      index_q  <= index_d;
      freed_q  <= freed_d;
      ftime_q  <= ftime_d;
    end
  end

  // slice start times
  always_ff @(posedge clk_i) begin
    if (start_we) begin
      start_mem[free_idx] <= ex_cmd_q.now;
    end
  end

  // accumulated busy times
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[ex_cmd_q.slot] <= acc_new;
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign slice_index_o     = index_q;
  assign slice_freed_o     = freed_q;
  assign slices_busy_o     = count_q;
  assign peak_slice_o      = peak_q;
  assign freed_busy_time_o = ftime_q;

endmodule

`default_nettype wire
